/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define PPPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset
`define PPPS_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PPPS_ASSERT(label, clk, rst_n, prop, msg)
`define PPPS_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* rtl/ppps_pkg.sv */
// Types and constants for the parallel printer port sender
`default_nettype none

package ppps_pkg;

    localparam int FIFO_DEPTH_DEF = 128;
    localparam int BYTE_W         = 8;
    localparam int TICK_W         = 20;
    localparam int STROBE_W       = 8;
    localparam int LIMIT_W        = 8;
    localparam int LEVEL_W        = 8;
    localparam int CFG_DATA_W     = 20;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [STROBE_W-1:0] STROBE_WIDTH_RST = STROBE_W'(5);
    localparam logic [TICK_W-1:0]   ACK_TIMEOUT_RST  = TICK_W'(100999);
    localparam logic [LIMIT_W-1:0]  BUFFER_LIMIT_RST = LIMIT_W'(100);
    localparam logic [TICK_W-1:0]   TICK_MAX         = {TICK_W{1'b1}};

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_READY    = 2'd0,
        MODE_STROBE   = 2'd1,
        MODE_ACK_RISE = 2'd2,
        MODE_ACK_FALL = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STROBE_WIDTH = 2'd0,
        REG_ACK_TIMEOUT  = 2'd1,
        REG_BUFFER_LIMIT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [BYTE_W-1:0] out_byte;
        logic              ack_line;
        logic              busy_line;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_lines;
        logic               strobe_line;
        logic [1:0]         port_mode;
        logic               space_available;
        logic [LEVEL_W-1:0] fill_level;
        logic               push_dropped;
    } status_t;

endpackage

`default_nettype wire

/* rtl/ppps_ram.sv */
// Generic single write port RAM with registered read
`default_nettype none

module ppps_ram #(
    parameter int WIDTH = ppps_pkg::BYTE_W,
    parameter int DEPTH = ppps_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/parallel_printer_port_sender.sv */
// Parallel printer port sender: byte FIFO and strobe/ack handshake machine
// An accepted transaction passes through the command register, then the status
// register, before its status is valid.
// Throughput: one transaction per cycle while the status output is not stalled; the
// FIFO RAM head read is registered and bypassed when a push lands on the head entry.
// Reset: empty FIFO, ready mode, strobe low, registers at defaults; no clear sweep.
`default_nettype none
`include "assert_macros.svh"

module parallel_printer_port_sender #(
    parameter int FIFO_DEPTH = ppps_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_stall,
    input  wire ppps_pkg::cmd_t                      cmd,
    output logic                                     status_valid,
    input  wire logic                                status_stall,
    output ppps_pkg::status_t                        status,
    input  wire logic                                cfg_we,
    input  wire logic [ppps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ppps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (CNT_W > ppps_pkg::LEVEL_W) ? CNT_W : ppps_pkg::LEVEL_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(FIFO_DEPTH);

    logic                               in_valid_reg, in_valid_next;
    ppps_pkg::cmd_t                     in_reg;
    logic                               out_valid_reg, out_valid_next;
    ppps_pkg::status_t                  out_reg, out_next;

    ppps_pkg::mode_t                    mode_reg, mode_next;
    logic [PTR_W-1:0]                   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [ppps_pkg::BYTE_W-1:0]        held_reg, held_next;
    logic                               strobe_reg, strobe_next;
    logic [ppps_pkg::TICK_W-1:0]        elapsed_reg, elapsed_next;

    logic [ppps_pkg::STROBE_W-1:0]      strobe_width_reg;
    logic [ppps_pkg::TICK_W-1:0]        ack_timeout_reg;
    logic [ppps_pkg::LIMIT_W-1:0]       buffer_limit_reg;

    logic                               byp_valid_reg, byp_valid_next;
    logic [ppps_pkg::BYTE_W-1:0]        byp_data_reg;

    logic                               out_load, process;
    logic                               is_tick, is_push, is_clear;
    logic                               fifo_empty, fifo_full;
    logic                               pop, push_ok, dropped;
    logic [ppps_pkg::TICK_W-1:0]        elapsed_inc;
    logic                               strobe_done, ack_expired;
    logic [PTR_W-1:0]                   ptr_inc, wr_addr;
    logic [SUM_W-1:0]                   wr_sum;
    logic [ppps_pkg::BYTE_W-1:0]        ram_rdata, head_data;
    logic [CMP_W-1:0]                   count_next_ext;

    // Pipeline control
    assign out_load  = !out_valid_reg || !status_stall;
    assign process   = in_valid_reg && out_load;
    assign cmd_stall = in_valid_reg && !out_load;

    assign in_valid_next  = (cmd_valid && !cmd_stall) ? 1'b1 : (process ? 1'b0 : in_valid_reg);
    assign out_valid_next = process ? 1'b1 : (status_stall ? out_valid_reg : 1'b0);

    assign is_tick  = process && (in_reg.op == ppps_pkg::OP_TICK);
    assign is_push  = process && (in_reg.op == ppps_pkg::OP_PUSH);
    assign is_clear = process && (in_reg.op == ppps_pkg::OP_CLEAR);

    assign fifo_empty = (count_reg == '0);
    assign fifo_full  = (count_reg == CNT_FULL);
    assign pop        = is_tick && (mode_reg == ppps_pkg::MODE_READY)
                        && !in_reg.busy_line && !fifo_empty;
    assign push_ok    = is_push && !fifo_full;
    assign dropped    = is_push && fifo_full;

    assign elapsed_inc = (elapsed_reg == ppps_pkg::TICK_MAX) ? elapsed_reg
                                                             : elapsed_reg + 1'b1;
    assign strobe_done = elapsed_inc > ppps_pkg::TICK_W'(strobe_width_reg);
    assign ack_expired = elapsed_inc > ack_timeout_reg;

    // FIFO addressing
    assign ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_sum  = SUM_W'(rd_ptr_reg) + SUM_W'(count_reg);
    assign wr_addr = (wr_sum >= SUM_DEPTH) ? PTR_W'(wr_sum - SUM_DEPTH) : PTR_W'(wr_sum);

    assign rd_ptr_next = is_clear ? '0 : (pop ? ptr_inc : rd_ptr_reg);
    assign count_next  = is_clear ? '0 :
                         pop      ? count_reg - 1'b1 :
                         push_ok  ? count_reg + 1'b1 : count_reg;

    // Push landing on the entry being read: RAM output is stale next cycle
    assign byp_valid_next = push_ok && (wr_addr == rd_ptr_next);
    assign head_data      = byp_valid_reg ? byp_data_reg : ram_rdata;

    ppps_ram #(
        .WIDTH (ppps_pkg::BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (wr_addr),
        .wdata (in_reg.out_byte),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    // Handshake next state
    always_comb
    begin
        mode_next = mode_reg;
        if (is_tick)
        begin
            case (mode_reg)
                ppps_pkg::MODE_READY:
                begin
                    if (!in_reg.busy_line && !fifo_empty)
                    begin
                        mode_next = ppps_pkg::MODE_STROBE;
                    end
                end
                ppps_pkg::MODE_STROBE:
                begin
                    if (strobe_done)
                    begin
                        mode_next = ppps_pkg::MODE_ACK_RISE;
                    end
                end
                ppps_pkg::MODE_ACK_RISE:
                begin
                    if (in_reg.ack_line)
                    begin
                        mode_next = ppps_pkg::MODE_ACK_FALL;
                    end
                    else if (ack_expired)
                    begin
                        mode_next = ppps_pkg::MODE_READY;
                    end
                end
                ppps_pkg::MODE_ACK_FALL:
                begin
                    if (!in_reg.ack_line)
                    begin
                        mode_next = ppps_pkg::MODE_READY;
                    end
                end
                default:
                begin
                    mode_next = ppps_pkg::MODE_READY;
                end
            endcase
        end
    end

    // Handshake outputs: data, strobe, tick counter
    always_comb
    begin
        held_next    = held_reg;
        strobe_next  = strobe_reg;
        elapsed_next = elapsed_reg;
        if (is_tick)
        begin
            case (mode_reg)
                ppps_pkg::MODE_READY:
                begin
                    if (pop)
                    begin
                        held_next    = head_data;
                        strobe_next  = 1'b1;
                        elapsed_next = '0;
                    end
                end
                ppps_pkg::MODE_STROBE:
                begin
                    if (strobe_done)
                    begin
                        strobe_next  = 1'b0;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
                ppps_pkg::MODE_ACK_RISE:
                begin
                    elapsed_next = elapsed_inc;
                end
                default:
                begin
                    elapsed_next = elapsed_reg;
                end
            endcase
        end
    end

    // Status transaction
    assign count_next_ext = CMP_W'(count_next);

    always_comb
    begin
        out_next.data_lines      = held_next;
        out_next.strobe_line     = strobe_next;
        out_next.port_mode       = 2'(mode_next);
        out_next.space_available = count_next_ext < CMP_W'(buffer_limit_reg);
        out_next.fill_level      = count_next_ext[ppps_pkg::LEVEL_W-1:0];
        out_next.push_dropped    = dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            mode_reg         <= ppps_pkg::MODE_READY;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
            held_reg         <= '0;
            strobe_reg       <= 1'b0;
            elapsed_reg      <= '0;
            byp_valid_reg    <= 1'b0;
            strobe_width_reg <= ppps_pkg::STROBE_WIDTH_RST;
            ack_timeout_reg  <= ppps_pkg::ACK_TIMEOUT_RST;
            buffer_limit_reg <= ppps_pkg::BUFFER_LIMIT_RST;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            held_reg      <= held_next;
            strobe_reg    <= strobe_next;
            elapsed_reg   <= elapsed_next;
            byp_valid_reg <= byp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ppps_pkg::REG_STROBE_WIDTH:
                    begin
                        strobe_width_reg <= cfg_data[ppps_pkg::STROBE_W-1:0];
                    end
                    ppps_pkg::REG_ACK_TIMEOUT:
                    begin
                        ack_timeout_reg <= cfg_data[ppps_pkg::TICK_W-1:0];
                    end
                    ppps_pkg::REG_BUFFER_LIMIT:
                    begin
                        buffer_limit_reg <= cfg_data[ppps_pkg::LIMIT_W-1:0];
                    end
                    default:
                    begin
                        buffer_limit_reg <= buffer_limit_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            in_reg <= cmd;
        end
        if (process)
        begin
            out_reg <= out_next;
        end
        byp_data_reg <= in_reg.out_byte;
    end

    assign status_valid = out_valid_reg;
    assign status       = out_reg;

    `PPPS_NEVER(a_count_bound, clk, rst_n, count_reg > CNT_FULL, "FIFO count above depth")
    `PPPS_ASSERT(a_strobe_mode, clk, rst_n,
        strobe_reg == (mode_reg == ppps_pkg::MODE_STROBE),
        "strobe level disagrees with handshake mode")
    `PPPS_ASSERT(a_level_match, clk, rst_n,
        out_valid_reg |-> (out_reg.fill_level == ppps_pkg::LEVEL_W'(count_reg)),
        "held status fill level disagrees with FIFO count")
    `PPPS_ASSERT(a_drop_full, clk, rst_n,
        (out_valid_reg && out_reg.push_dropped) |-> fifo_full,
        "dropped push reported while FIFO not full")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for parallel_printer_port_sender: table-driven and random transactions with a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = ppps_pkg::FIFO_DEPTH_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 6;
    localparam int N_DIRECTED = 24;

    typedef struct {
        ppps_pkg::cmd_t    c;
        bit                typed;
        ppps_pkg::status_t s;
    } dir_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cmd_valid;
    logic                             cmd_stall;
    ppps_pkg::cmd_t                   cmd;
    logic                             status_valid;
    logic                             status_stall;
    ppps_pkg::status_t                status;
    logic                             cfg_we;
    logic [ppps_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ppps_pkg::CFG_DATA_W-1:0]  cfg_data;

    parallel_printer_port_sender dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .status_valid (status_valid),
        .status_stall (status_stall),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state
    logic [ppps_pkg::BYTE_W-1:0]   fifo_mem [DEPTH];
    int                            fifo_head;
    int                            fifo_count;
    ppps_pkg::mode_t               hs_mode;
    logic [ppps_pkg::BYTE_W-1:0]   hs_data;
    logic                          hs_strobe;
    logic [ppps_pkg::TICK_W-1:0]   hs_elapsed;
    logic [ppps_pkg::STROBE_W-1:0] strobe_width;
    logic [ppps_pkg::TICK_W-1:0]   ack_timeout;
    logic [ppps_pkg::LIMIT_W-1:0]  buf_limit;

    ppps_pkg::status_t pending_status [$];
    dir_row_t dir_tab [N_DIRECTED];

    int snd_idle_pct;
    int rcv_idle_pct;
    int push_pct;
    int clear_pct;
    int busy_pct;
    int ack_pct;
    bit hold_req;
    int fails;
    int idle_cycles;
    int n_items;
    int n_pops;
    int n_timeouts;
    int n_drops;
    int n_settings;
    ppps_pkg::status_t want;
    bit ok;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic ppps_pkg::cmd_t cmd_of(input logic [1:0] op, input logic [7:0] b,
                                              input logic ack, input logic busy);
        ppps_pkg::cmd_t c;
        c.op = op;
        c.out_byte = b;
        c.ack_line = ack;
        c.busy_line = busy;
        return c;
    endfunction

    function automatic ppps_pkg::status_t status_of(input logic [7:0] d, input logic stb,
                                                    input ppps_pkg::mode_t m,
                                                    input logic space,
                                                    input logic [7:0] fill,
                                                    input logic drop);
        ppps_pkg::status_t s;
        s.data_lines = d;
        s.strobe_line = stb;
        s.port_mode = m;
        s.space_available = space;
        s.fill_level = fill;
        s.push_dropped = drop;
        return s;
    endfunction

    function automatic ppps_pkg::status_t port_next_status(input ppps_pkg::cmd_t c);
        ppps_pkg::status_t s;
        logic dropped;
        dropped = 1'b0;
        case (c.op)
            ppps_pkg::OP_TICK:
            begin
                case (hs_mode)
                    ppps_pkg::MODE_STROBE:
                    begin
                        if (hs_elapsed != ppps_pkg::TICK_MAX)
                            hs_elapsed++;
                        if (hs_elapsed > ppps_pkg::TICK_W'(strobe_width))
                        begin
                            hs_strobe = 1'b0;
                            hs_elapsed = '0;
                            hs_mode = ppps_pkg::MODE_ACK_RISE;
                        end
                    end
                    ppps_pkg::MODE_ACK_RISE:
                    begin
                        if (hs_elapsed != ppps_pkg::TICK_MAX)
                            hs_elapsed++;
                        if (c.ack_line)
                            hs_mode = ppps_pkg::MODE_ACK_FALL;
                        else if (hs_elapsed > ack_timeout)
                        begin
                            hs_mode = ppps_pkg::MODE_READY;
                            n_timeouts++;
                        end
                    end
                    ppps_pkg::MODE_ACK_FALL:
                    begin
                        if (!c.ack_line)
                            hs_mode = ppps_pkg::MODE_READY;
                    end
                    default:
                    begin
                        if (!c.busy_line && fifo_count != 0)
                        begin
                            hs_data = fifo_mem[fifo_head];
                            fifo_head = (fifo_head + 1) % DEPTH;
                            fifo_count--;
                            hs_strobe = 1'b1;
                            hs_elapsed = '0;
                            hs_mode = ppps_pkg::MODE_STROBE;
                            n_pops++;
                        end
                    end
                endcase
            end
            ppps_pkg::OP_PUSH:
            begin
                if (fifo_count >= DEPTH)
                begin
                    dropped = 1'b1;
                    n_drops++;
                end
                else
                begin
                    fifo_mem[(fifo_head + fifo_count) % DEPTH] = c.out_byte;
                    fifo_count++;
                end
            end
            ppps_pkg::OP_CLEAR:
            begin
                fifo_head = 0;
                fifo_count = 0;
            end
            default: ;
        endcase
        s.data_lines = hs_data;
        s.strobe_line = hs_strobe;
        s.port_mode = hs_mode;
        s.space_available = (fifo_count < buf_limit);
        s.fill_level = ppps_pkg::LEVEL_W'(fifo_count);
        s.push_dropped = dropped;
        return s;
    endfunction

    // printer-like ack behavior in the handshake waits, noise elsewhere
    function automatic ppps_pkg::cmd_t pick_cmd();
        ppps_pkg::cmd_t c;
        int r;
        c.out_byte = 8'($urandom);
        r = $urandom_range(99);
        if (r < clear_pct)
            c.op = ppps_pkg::OP_CLEAR;
        else if (r < clear_pct + 3)
            c.op = OP_UNUSED;
        else if (r < clear_pct + 3 + push_pct)
            c.op = ppps_pkg::OP_PUSH;
        else
            c.op = ppps_pkg::OP_TICK;
        c.busy_line = ($urandom_range(99) < busy_pct);
        case (hs_mode)
            ppps_pkg::MODE_ACK_RISE: c.ack_line = ($urandom_range(99) < ack_pct);
            ppps_pkg::MODE_ACK_FALL: c.ack_line = ($urandom_range(99) < 60);
            default:                 c.ack_line = 1'($urandom_range(1));
        endcase
        return c;
    endfunction

    function automatic bit field_ok(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] got_v);
        if (exp_v === got_v)
            return 1'b1;
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        return 1'b0;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_cmd(input ppps_pkg::cmd_t c, input bit use_typed = 1'b0,
                            input ppps_pkg::status_t typed_s = '0);
        ppps_pkg::status_t pred;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        pred = port_next_status(c);
        pending_status.push_back(use_typed ? typed_s : pred);
        n_items++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_status.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] sw, input logic [19:0] to,
                                  input logic [7:0] lim);
        cfg_we <= 1'b1;
        cfg_index <= ppps_pkg::REG_STROBE_WIDTH;
        cfg_data <= ppps_pkg::CFG_DATA_W'(sw);
        @(negedge clk);
        cfg_index <= ppps_pkg::REG_ACK_TIMEOUT;
        cfg_data <= to;
        @(negedge clk);
        cfg_index <= ppps_pkg::REG_BUFFER_LIMIT;
        cfg_data <= ppps_pkg::CFG_DATA_W'(lim);
        @(negedge clk);
        cfg_we <= 1'b0;
        strobe_width = sw;
        ack_timeout = to;
        buf_limit = lim;
        n_settings++;
    endtask

    task automatic run_phase(input logic [7:0] sw, input logic [19:0] to,
                             input logic [7:0] lim, input int snd, input int rcv,
                             input int push, input int clr, input int busy,
                             input int ackp, input int n, input bit hold);
        cmd_valid <= 1'b0;
        wait_idle();
        apply_settings(sw, to, lim);
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
        push_pct = push;
        clear_pct = clr;
        busy_pct = busy;
        ack_pct = ackp;
        hold_req = hold;
        repeat (n) send_cmd(pick_cmd());
    endtask

    // receiver: random stall, or a long hold-off on request
    initial
    begin
        status_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                status_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            status_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && status_valid && !status_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $error("status transaction with nothing expected");
                fails++;
            end
            else
            begin
                want = pending_status.pop_front();
                ok = field_ok("data_lines", want.data_lines, status.data_lines);
                ok = field_ok("strobe_line", want.strobe_line, status.strobe_line) & ok;
                ok = field_ok("port_mode", want.port_mode, status.port_mode) & ok;
                ok = field_ok("space_available", want.space_available,
                              status.space_available) & ok;
                ok = field_ok("fill_level", want.fill_level, status.fill_level) & ok;
                ok = field_ok("push_dropped", want.push_dropped, status.push_dropped) & ok;
                if (!ok)
                    fails++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (status_valid && !status_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        fails = 0;
        idle_cycles = 0;
        n_items = 0;
        n_pops = 0;
        n_timeouts = 0;
        n_drops = 0;
        n_settings = 0;
        fifo_head = 0;
        fifo_count = 0;
        hs_mode = ppps_pkg::MODE_READY;
        hs_data = '0;
        hs_strobe = 1'b0;
        hs_elapsed = '0;
        strobe_width = ppps_pkg::STROBE_WIDTH_RST;
        ack_timeout = ppps_pkg::ACK_TIMEOUT_RST;
        buf_limit = ppps_pkg::BUFFER_LIMIT_RST;
        snd_idle_pct = 7;
        rcv_idle_pct = 58;

        // reset defaults: strobe width 5, limit 100
        dir_tab[0]  = '{cmd_of(ppps_pkg::OP_TICK, 8'h00, 0, 0), 1'b1,
                        status_of(8'h00, 0, ppps_pkg::MODE_READY, 1, 8'd0, 0)};
        dir_tab[1]  = '{cmd_of(OP_UNUSED, 8'hFF, 1, 1), 1'b1,
                        status_of(8'h00, 0, ppps_pkg::MODE_READY, 1, 8'd0, 0)};
        dir_tab[2]  = '{cmd_of(ppps_pkg::OP_PUSH, 8'h00, 0, 0), 1'b1,
                        status_of(8'h00, 0, ppps_pkg::MODE_READY, 1, 8'd1, 0)};
        dir_tab[3]  = '{cmd_of(ppps_pkg::OP_PUSH, 8'hFF, 1, 1), 1'b1,
                        status_of(8'h00, 0, ppps_pkg::MODE_READY, 1, 8'd2, 0)};
        dir_tab[4]  = '{cmd_of(ppps_pkg::OP_CLEAR, 8'h00, 0, 0), 1'b1,
                        status_of(8'h00, 0, ppps_pkg::MODE_READY, 1, 8'd0, 0)};
        dir_tab[5]  = '{cmd_of(ppps_pkg::OP_PUSH, 8'hA5, 0, 0), 1'b1,
                        status_of(8'h00, 0, ppps_pkg::MODE_READY, 1, 8'd1, 0)};
        dir_tab[6]  = '{cmd_of(ppps_pkg::OP_PUSH, 8'h5A, 0, 0), 1'b1,
                        status_of(8'h00, 0, ppps_pkg::MODE_READY, 1, 8'd2, 0)};
        dir_tab[7]  = '{cmd_of(ppps_pkg::OP_TICK, 8'h00, 0, 1), 1'b1,
                        status_of(8'h00, 0, ppps_pkg::MODE_READY, 1, 8'd2, 0)};
        dir_tab[8]  = '{cmd_of(ppps_pkg::OP_TICK, 8'h00, 1, 0), 1'b1,
                        status_of(8'hA5, 1, ppps_pkg::MODE_STROBE, 1, 8'd1, 0)};
        for (int i = 9; i < 15; i++)
            dir_tab[i] = '{cmd_of(ppps_pkg::OP_TICK, 8'h00, 0, 0), 1'b0, '0};
        // clear and push in the middle of a handshake, then ack rise and fall
        dir_tab[15] = '{cmd_of(ppps_pkg::OP_CLEAR, 8'h00, 0, 0), 1'b0, '0};
        dir_tab[16] = '{cmd_of(ppps_pkg::OP_PUSH, 8'h3C, 0, 0), 1'b0, '0};
        dir_tab[17] = '{cmd_of(ppps_pkg::OP_TICK, 8'h00, 0, 0), 1'b0, '0};
        dir_tab[18] = '{cmd_of(ppps_pkg::OP_TICK, 8'h00, 1, 0), 1'b0, '0};
        dir_tab[19] = '{cmd_of(ppps_pkg::OP_TICK, 8'h00, 1, 1), 1'b0, '0};
        dir_tab[20] = '{cmd_of(ppps_pkg::OP_TICK, 8'h00, 0, 0), 1'b0, '0};
        dir_tab[21] = '{cmd_of(ppps_pkg::OP_TICK, 8'h00, 0, 0), 1'b0, '0};
        dir_tab[22] = '{cmd_of(ppps_pkg::OP_PUSH, 8'h80, 1, 0), 1'b0, '0};
        dir_tab[23] = '{cmd_of(OP_UNUSED, 8'h00, 0, 0), 1'b0, '0};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].s);

        run_phase(8'd0, 20'd0, 8'd0, 7, 58, 35, 5, 20, 40, 100, 1'b0);
        run_phase(8'd255, ppps_pkg::TICK_MAX, 8'd128, 7, 58, 35, 5, 20, 30, 100, 1'b0);
        run_phase(8'd3, 20'd20, 8'd8, 58, 7, 30, 4, 20, 8, 120, 1'b1);
        run_phase(8'd1, 20'd5, 8'd128, 58, 7, 85, 0, 100, 30, 170, 1'b0);
        run_phase(8'($urandom_range(12)), 20'($urandom_range(40)),
                  8'($urandom_range(128)), 0, 0, 25, 4, 15, 30, 150, 1'b0);
        run_phase(ppps_pkg::STROBE_WIDTH_RST, ppps_pkg::ACK_TIMEOUT_RST,
                  ppps_pkg::BUFFER_LIMIT_RST, 0, 0, 35, 4, 20, 30, 100, 1'b0);
        run_phase(8'($urandom_range(12)), 20'($urandom_range(40)),
                  8'($urandom_range(128)), 0, 0, 30, 4, 20, 20, 90, 1'b0);

        cmd_valid <= 1'b0;
        wait_idle();
        if (pending_status.size() != 0)
        begin
            $error("%0d status transactions never arrived", pending_status.size());
            fails++;
        end
        $display("Ran %0d transactions over %0d register settings", n_items, n_settings);
        $display("Bytes strobed %0d, ack timeouts %0d, pushes dropped %0d, mismatches %0d",
                 n_pops, n_timeouts, n_drops, fails);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
